// ===== rtl/core/btsp_pkg.sv =====
package btsp_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int CORDIC_STAGES_MAX = 24;

    localparam int LAT_W = 31;
    localparam int LON_W = 32;
    localparam int ANG_W = 33;
    localparam int TRIG_W = 32;
    localparam int PULSE_W = 12;
    localparam int BEARING_W = 16;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SERVO_MIN    = 2'd0,
        CFG_SERVO_MAX    = 2'd1,
        CFG_SERVO_CENTER = 2'd2
    } cfg_idx_t;

    localparam logic [PULSE_W-1:0] SERVO_MIN_RST    = 12'd500;
    localparam logic [PULSE_W-1:0] SERVO_MAX_RST    = 12'd2500;
    localparam logic [PULSE_W-1:0] SERVO_CENTER_RST = 12'd1500;

    // angles in 1e-7 degree
    localparam logic signed [34:0] DEG90  = 35'sd900000000;
    localparam logic signed [34:0] DEG180 = 35'sd1800000000;
    localparam logic signed [34:0] DEG360 = 35'sd3600000000;

    // 0.60725293 in q30
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN_INV = 32'sd652032874;

    // reciprocals for exact division by constants
    localparam logic [26:0] RECIP_3125  = 27'd87960931;
    localparam logic [24:0] RECIP_78125 = 25'd28147498;
    localparam logic [20:0] RECIP_180   = 21'd1491309;
    localparam logic [20:0] RECIP_89    = 21'd1508065;

    function automatic logic signed [31:0] atan_entry(input int idx);
        logic signed [31:0] r;
        case (idx)
            0:  r = 32'sd450000000;
            1:  r = 32'sd265650512;
            2:  r = 32'sd140362435;
            3:  r = 32'sd71250163;
            4:  r = 32'sd35763344;
            5:  r = 32'sd17899106;
            6:  r = 32'sd8951737;
            7:  r = 32'sd4476142;
            8:  r = 32'sd2238105;
            9:  r = 32'sd1119057;
            10: r = 32'sd559529;
            11: r = 32'sd279765;
            12: r = 32'sd139882;
            13: r = 32'sd69941;
            14: r = 32'sd34971;
            15: r = 32'sd17485;
            16: r = 32'sd8743;
            17: r = 32'sd4371;
            18: r = 32'sd2186;
            19: r = 32'sd1093;
            20: r = 32'sd546;
            21: r = 32'sd273;
            22: r = 32'sd137;
            23: r = 32'sd68;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/btsp_cordic_rot.sv =====
module btsp_cordic_rot #(
    parameter int STAGES = btsp_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [btsp_pkg::ANG_W-1:0]     angle,
    output logic signed [btsp_pkg::TRIG_W-1:0]    sin_val,
    output logic signed [btsp_pkg::TRIG_W-1:0]    cos_val
);

    logic signed [34:0] a_ext;
    logic signed [34:0] a_wrap;
    logic signed [34:0] a_fold;
    logic               fold;

    logic signed [btsp_pkg::TRIG_W-1:0] x_reg [0:STAGES];
    logic signed [btsp_pkg::TRIG_W-1:0] y_reg [0:STAGES];
    logic signed [31:0]                 z_reg [0:STAGES];
    logic                               flip_reg [0:STAGES];

    // wrap to (-180, 180] then fold into +-90
    always_comb
    begin
        a_ext = 35'(angle);
        if (a_ext > btsp_pkg::DEG180)
        begin
            a_wrap = a_ext - btsp_pkg::DEG360;
        end
        else if (a_ext <= -btsp_pkg::DEG180)
        begin
            a_wrap = a_ext + btsp_pkg::DEG360;
        end
        else
        begin
            a_wrap = a_ext;
        end
        if (a_wrap > btsp_pkg::DEG90)
        begin
            a_fold = a_wrap - btsp_pkg::DEG180;
            fold   = 1'b1;
        end
        else if (a_wrap < -btsp_pkg::DEG90)
        begin
            a_fold = a_wrap + btsp_pkg::DEG180;
            fold   = 1'b1;
        end
        else
        begin
            a_fold = a_wrap;
            fold   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= btsp_pkg::CORDIC_GAIN_INV;
            y_reg[0]    <= '0;
            z_reg[0]    <= 32'(a_fold);
            flip_reg[0] <= fold;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - btsp_pkg::atan_entry(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + btsp_pkg::atan_entry(i);
                end
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    assign sin_val = flip_reg[STAGES] ? -y_reg[STAGES] : y_reg[STAGES];
    assign cos_val = flip_reg[STAGES] ? -x_reg[STAGES] : x_reg[STAGES];

endmodule

// ===== rtl/core/btsp_cordic_vec.sv =====
module btsp_cordic_vec #(
    parameter int STAGES = btsp_pkg::CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] v_in,
    input  logic signed [32:0] u_in,
    output logic signed [31:0] angle
);

    logic signed [34:0] u0;
    logic signed [34:0] v0;
    logic signed [33:0] z0;
    logic               zero;

    logic signed [34:0] u_reg [0:STAGES];
    logic signed [34:0] v_reg [0:STAGES];
    logic signed [33:0] z_reg [0:STAGES];
    logic               zero_reg [0:STAGES];

    // left half plane: rotate by 180 first
    always_comb
    begin
        zero = (u_in == 0) && (v_in == 0);
        if (u_in < 0)
        begin
            u0 = -35'(u_in);
            v0 = -35'(v_in);
            z0 = (v_in >= 0) ? 34'(btsp_pkg::DEG180) : -34'(btsp_pkg::DEG180);
        end
        else
        begin
            u0 = 35'(u_in);
            v0 = 35'(v_in);
            z0 = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg[0]    <= u0;
            v_reg[0]    <= v0;
            z_reg[0]    <= z0;
            zero_reg[0] <= zero;
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (v_reg[i] > 0)
                begin
                    u_reg[i+1] <= u_reg[i] + (v_reg[i] >>> i);
                    v_reg[i+1] <= v_reg[i] - (u_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + 34'(btsp_pkg::atan_entry(i));
                end
                else
                begin
                    u_reg[i+1] <= u_reg[i] - (v_reg[i] >>> i);
                    v_reg[i+1] <= v_reg[i] + (u_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - 34'(btsp_pkg::atan_entry(i));
                end
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    always_comb
    begin
        if (zero_reg[STAGES])
        begin
            angle = '0;
        end
        else if (35'(z_reg[STAGES]) > btsp_pkg::DEG180)
        begin
            angle = 32'(btsp_pkg::DEG180);
        end
        else if (35'(z_reg[STAGES]) < -btsp_pkg::DEG180)
        begin
            angle = -32'(btsp_pkg::DEG180);
        end
        else
        begin
            angle = 32'(z_reg[STAGES]);
        end
    end

endmodule

// ===== rtl/core/bearing_to_servo_position.sv =====
// throughput: one request per cycle; the whole pipeline advances together and
// holds when the output register is full and not taken
// the depth is set by the two unrolled cordic chains, one stage per iteration
// reset: asynchronous, active low; clears all valid bits and loads the
// servo pulse registers with 500, 2500 and 1500
module bearing_to_servo_position #(
    parameter int CORDIC_STAGES = btsp_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [btsp_pkg::LAT_W-1:0]      origin_latitude,
    input  logic signed [btsp_pkg::LON_W-1:0]      origin_longitude,
    input  logic signed [btsp_pkg::LAT_W-1:0]      target_latitude,
    input  logic signed [btsp_pkg::LON_W-1:0]      target_longitude,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [btsp_pkg::BEARING_W-1:0]  bearing,
    output logic [btsp_pkg::PULSE_W-1:0]           servo_position,
    output logic                                   target_in_front,
    output logic                                   position_saturated,
    input  logic                                   cfg_write_en,
    input  logic [btsp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [btsp_pkg::PULSE_W-1:0]           cfg_data
);

    localparam int LAT = 2 * CORDIC_STAGES + 11;

    logic en;
    logic [LAT-1:0] valid_reg;

    logic [btsp_pkg::PULSE_W-1:0] min_reg;
    logic [btsp_pkg::PULSE_W-1:0] max_reg;
    logic [btsp_pkg::PULSE_W-1:0] center_reg;

    assign en        = !valid_reg[LAT-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = valid_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg    <= btsp_pkg::SERVO_MIN_RST;
            max_reg    <= btsp_pkg::SERVO_MAX_RST;
            center_reg <= btsp_pkg::SERVO_CENTER_RST;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                btsp_pkg::CFG_SERVO_MIN:    min_reg    <= cfg_data;
                btsp_pkg::CFG_SERVO_MAX:    max_reg    <= cfg_data;
                btsp_pkg::CFG_SERVO_CENTER: center_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    logic signed [btsp_pkg::LAT_W-1:0] lat1_reg, lat2_reg;
    logic signed [btsp_pkg::LON_W-1:0] lon1_reg, lon2_reg;
    logic signed [btsp_pkg::ANG_W-1:0] dlon;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lat1_reg <= origin_latitude;
            lon1_reg <= origin_longitude;
            lat2_reg <= target_latitude;
            lon2_reg <= target_longitude;
        end
    end

    assign dlon = 33'(lon2_reg) - 33'(lon1_reg);

    logic signed [btsp_pkg::TRIG_W-1:0] s1, c1, s2, c2, sd, cd;

    btsp_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_lat1 (
        .clk(clk), .en(en), .angle(33'(lat1_reg)), .sin_val(s1), .cos_val(c1)
    );
    btsp_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_lat2 (
        .clk(clk), .en(en), .angle(33'(lat2_reg)), .sin_val(s2), .cos_val(c2)
    );
    btsp_cordic_rot #(.STAGES(CORDIC_STAGES)) u_rot_dlon (
        .clk(clk), .en(en), .angle(dlon), .sin_val(sd), .cos_val(cd)
    );

    // q30 products
    logic signed [63:0] p_ex, p_t1, p_t2, p_ny;
    logic signed [31:0] ex_reg, t1_reg, t2_reg, cd_reg;
    logic signed [31:0] ex2_reg;
    logic signed [32:0] ny_reg;

    assign p_ex = c2 * sd;
    assign p_t1 = c1 * s2;
    assign p_t2 = s1 * c2;
    assign p_ny = t2_reg * cd_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ex_reg  <= $signed(p_ex[61:30]);
            t1_reg  <= $signed(p_t1[61:30]);
            t2_reg  <= $signed(p_t2[61:30]);
            cd_reg  <= cd;
            ex2_reg <= ex_reg;
            ny_reg  <= 33'(t1_reg) - 33'($signed(p_ny[61:30]));
        end
    end

    logic signed [31:0] z_vec;

    btsp_cordic_vec #(.STAGES(CORDIC_STAGES)) u_vec (
        .clk(clk), .en(en), .v_in(ex2_reg), .u_in(ny_reg), .angle(z_vec)
    );

    // post-processing stages
    logic signed [31:0] z_reg;
    logic [31:0] mag;
    logic [25:0] n1_reg;
    logic [23:0] n2_reg;
    logic        neg_b_reg, front_b_reg, neg_c_reg, front_c_reg;
    logic [52:0] p_h;
    logic [48:0] p_d;
    logic [14:0] qh_reg;
    logic [7:0]  md_reg;

    assign mag = (z_reg < 0) ? 32'(-z_reg) : 32'(z_reg);
    assign p_h = 53'(n1_reg) * 53'(btsp_pkg::RECIP_3125);
    assign p_d = 49'(n2_reg) * 49'(btsp_pkg::RECIP_78125);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg       <= z_vec;
            n1_reg      <= 26'((mag + 32'd50000) >> 5);
            n2_reg      <= 24'(mag >> 7);
            neg_b_reg   <= z_reg < 0;
            front_b_reg <= mag < 32'(btsp_pkg::DEG90);
            qh_reg      <= p_h[52:38];
            md_reg      <= p_d[48:41];
            neg_c_reg   <= neg_b_reg;
            front_c_reg <= front_b_reg;
        end
    end

    // linear map: trunc(k * diff / span) + base
    logic signed [9:0]  k;
    logic signed [12:0] diff;
    logic signed [22:0] p_map;
    logic [11:0]        base;

    always_comb
    begin
        if (front_c_reg)
        begin
            k    = neg_c_reg ? 10'sd90 - $signed({2'b0, md_reg})
                             : 10'sd90 + $signed({2'b0, md_reg});
            diff = $signed({1'b0, max_reg}) - $signed({1'b0, min_reg});
            base = min_reg;
        end
        else
        begin
            k    = $signed({2'b0, md_reg}) - 10'sd91;
            diff = neg_c_reg ? $signed({1'b0, max_reg}) - $signed({1'b0, center_reg})
                             : $signed({1'b0, min_reg}) - $signed({1'b0, center_reg});
            base = center_reg;
        end
        p_map = 23'(k) * 23'(diff);
    end

    logic [19:0] pmag_reg;
    logic        pneg_d_reg, front_d_reg, pneg_e_reg, front_e_reg;
    logic [11:0] base_d_reg, base_e_reg;
    logic signed [15:0] bear_d_reg, bear_e_reg;
    logic [40:0] p_q;
    logic [12:0] q_e_reg;

    assign p_q = front_d_reg ? 41'(pmag_reg) * 41'(btsp_pkg::RECIP_180)
                             : 41'(pmag_reg) * 41'(btsp_pkg::RECIP_89);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pmag_reg    <= (p_map < 0) ? 20'(-p_map) : 20'(p_map);
            pneg_d_reg  <= p_map < 0;
            front_d_reg <= front_c_reg;
            base_d_reg  <= base;
            bear_d_reg  <= neg_c_reg ? -$signed({1'b0, qh_reg}) : $signed({1'b0, qh_reg});
            q_e_reg     <= front_d_reg ? p_q[40:28] : p_q[39:27];
            pneg_e_reg  <= pneg_d_reg;
            front_e_reg <= front_d_reg;
            base_e_reg  <= base_d_reg;
            bear_e_reg  <= bear_d_reg;
        end
    end

    logic signed [14:0] pos;
    logic [11:0] pos_sat;
    logic        sat;

    always_comb
    begin
        pos = (pneg_e_reg ? -$signed({2'b0, q_e_reg}) : $signed({2'b0, q_e_reg}))
              + $signed({3'b0, base_e_reg});
        if (pos < 0)
        begin
            pos_sat = '0;
            sat     = 1'b1;
        end
        else if (pos > 15'sd4095)
        begin
            pos_sat = 12'd4095;
            sat     = 1'b1;
        end
        else
        begin
            pos_sat = 12'(pos);
            sat     = 1'b0;
        end
    end

    logic signed [15:0] bearing_reg;
    logic [11:0]        servo_reg;
    logic               front_reg, sat_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bearing_reg <= bear_e_reg;
            servo_reg   <= pos_sat;
            front_reg   <= front_e_reg;
            sat_reg     <= sat;
        end
    end

    assign bearing            = bearing_reg;
    assign servo_position     = servo_reg;
    assign target_in_front    = front_reg;
    assign position_saturated = sat_reg;

    a_front_bearing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && target_in_front |-> (bearing <= 16'sd9000) && (bearing >= -16'sd9000))
        else $error("front flag with bearing beyond 90 degrees");

    a_behind_bearing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !target_in_front |-> (bearing >= 16'sd9000) || (bearing <= -16'sd9000))
        else $error("behind flag with bearing inside 90 degrees");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && position_saturated |->
            (servo_position == 12'd0) || (servo_position == 12'd4095))
        else $error("saturated flag with unclipped servo value");

endmodule

// ===== sim/bearing_servo_checker.sv =====
module bearing_servo_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_ready,
    input  logic signed [btsp_pkg::LAT_W-1:0]      origin_latitude,
    input  logic signed [btsp_pkg::LON_W-1:0]      origin_longitude,
    input  logic signed [btsp_pkg::LAT_W-1:0]      target_latitude,
    input  logic signed [btsp_pkg::LON_W-1:0]      target_longitude,
    input  logic                                   out_valid,
    input  logic                                   out_ready,
    input  logic signed [btsp_pkg::BEARING_W-1:0]  bearing,
    input  logic [btsp_pkg::PULSE_W-1:0]           servo_position,
    input  logic                                   target_in_front,
    input  logic                                   position_saturated,
    input  logic                                   cfg_write_en,
    input  logic [btsp_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [btsp_pkg::PULSE_W-1:0]           cfg_data,
    output int                                     fail_count,
    output int                                     pending_count
);

    typedef struct packed {
        logic signed [btsp_pkg::BEARING_W-1:0] bearing;
        logic [btsp_pkg::PULSE_W-1:0]          pulse;
        logic                                  front;
        logic                                  sat;
    } aim_t;

    localparam longint D90  = 64'sd900000000;
    localparam longint D180 = 64'sd1800000000;
    localparam longint D360 = 64'sd3600000000;

    aim_t   aim_queue[$];
    longint pulse_min, pulse_max, pulse_center;

    function automatic longint atan_step(input int i);
        longint t[24];
        t = '{450000000, 265650512, 140362435, 71250163, 35763344, 17899106,
              8951737, 4476142, 2238105, 1119057, 559529, 279765,
              139882, 69941, 34971, 17485, 8743, 4371,
              2186, 1093, 546, 273, 137, 68};
        return t[i];
    endfunction

    function automatic longint wrap_half_turn(input longint a);
        longint r;
        r = a % D360;
        if (r > D180) r -= D360;
        else if (r <= -D180) r += D360;
        return r;
    endfunction

    function automatic void rotate(input longint ang, output longint s, output longint c);
        longint x, y, z, dx, dy;
        bit flip;
        x = 652032874; y = 0; flip = 0;
        z = wrap_half_turn(ang);
        if (z > D90) begin z -= D180; flip = 1; end
        else if (z < -D90) begin z += D180; flip = 1; end
        for (int i = 0; i < btsp_pkg::CORDIC_STAGES_DEF; i++)
        begin
            dx = y >>> i; dy = x >>> i;
            if (z >= 0) begin x -= dx; y += dy; z -= atan_step(i); end
            else begin x += dx; y -= dy; z += atan_step(i); end
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic longint vector_angle(input longint v0, input longint u0);
        longint u, v, z, du, dv;
        u = u0; v = v0; z = 0;
        if (u == 0 && v == 0) return 0;
        if (u < 0)
        begin
            z = (v >= 0) ? D180 : -D180;
            u = -u; v = -v;
        end
        for (int i = 0; i < btsp_pkg::CORDIC_STAGES_DEF; i++)
        begin
            du = v >>> i; dv = u >>> i;
            if (v > 0) begin u += du; v -= dv; z += atan_step(i); end
            else begin u -= du; v += dv; z -= atan_step(i); end
        end
        if (z > D180) z = D180;
        if (z < -D180) z = -D180;
        return z;
    endfunction

    function automatic longint scale(input longint x, input longint a, input longint b,
                                     input longint c, input longint d);
        return (x - a) * (d - c) / (b - a) + c;
    endfunction

    function automatic aim_t predict_aim(input longint lat1, input longint lon1,
                                         input longint lat2, input longint lon2);
        longint s1, c1, s2, c2, sd, cd, ex, ny, z, mag, hund, deg, pos;
        aim_t r;
        rotate(lat1, s1, c1);
        rotate(lat2, s2, c2);
        rotate(lon2 - lon1, sd, cd);
        ex = (c2 * sd) >>> 30;
        ny = ((c1 * s2) >>> 30) - ((((s1 * c2) >>> 30) * cd) >>> 30);
        z = vector_angle(ex, ny);
        mag = z < 0 ? -z : z;
        hund = (mag + 50000) / 100000;
        if (z < 0) hund = -hund;
        deg = z / 10000000;
        r.front = mag < D90;
        if (r.front) pos = scale(deg, -90, 90, pulse_min, pulse_max);
        else if (z > 0) pos = scale(deg, 91, 180, pulse_center, pulse_min);
        else pos = scale(deg, -91, -180, pulse_center, pulse_max);
        r.sat = 0;
        if (pos < 0) begin pos = 0; r.sat = 1; end
        if (pos > 4095) begin pos = 4095; r.sat = 1; end
        r.bearing = hund[btsp_pkg::BEARING_W-1:0];
        r.pulse = pos[btsp_pkg::PULSE_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        aim_t got, want;
        if (!rst_n)
        begin
            pulse_min = btsp_pkg::SERVO_MIN_RST;
            pulse_max = btsp_pkg::SERVO_MAX_RST;
            pulse_center = btsp_pkg::SERVO_CENTER_RST;
            fail_count <= 0;
            aim_queue.delete();
            pending_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                aim_queue.push_back(predict_aim(origin_latitude, origin_longitude,
                                                target_latitude, target_longitude));
            if (out_valid && out_ready)
            begin
                got = '{bearing, servo_position, target_in_front, position_saturated};
                if (aim_queue.size() == 0)
                begin
                    if (fail_count < 10) $display("unexpected result %p", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = aim_queue.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected %p actual %p", want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending_count <= aim_queue.size();
            if (cfg_write_en)
            begin
                case (cfg_index)
                    btsp_pkg::CFG_SERVO_MIN:    pulse_min = cfg_data;
                    btsp_pkg::CFG_SERVO_MAX:    pulse_max = cfg_data;
                    btsp_pkg::CFG_SERVO_CENTER: pulse_center = cfg_data;
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== sim/tb_bearing_to_servo_position.sv =====
module tb_bearing_to_servo_position;

    logic clk, rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    logic signed [btsp_pkg::LAT_W-1:0] origin_latitude, target_latitude;
    logic signed [btsp_pkg::LON_W-1:0] origin_longitude, target_longitude;
    logic signed [btsp_pkg::BEARING_W-1:0] bearing;
    logic [btsp_pkg::PULSE_W-1:0] servo_position;
    logic target_in_front, position_saturated;
    logic cfg_write_en;
    logic [btsp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [btsp_pkg::PULSE_W-1:0] cfg_data;
    int fail_count, pending_count;
    int send_idle, recv_idle;
    int cycle_count = 0;
    bit hold_recv;

    bearing_to_servo_position dut (.*);

    bearing_servo_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= !hold_recv && ($urandom_range(99) >= recv_idle);

    task automatic send_request(input longint la1, input longint lo1,
                                input longint la2, input longint lo2);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        origin_latitude <= la1[btsp_pkg::LAT_W-1:0];
        origin_longitude <= lo1[btsp_pkg::LON_W-1:0];
        target_latitude <= la2[btsp_pkg::LAT_W-1:0];
        target_longitude <= lo2[btsp_pkg::LON_W-1:0];
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(input btsp_pkg::cfg_idx_t idx, input int val);
        cfg_write_en <= 1;
        cfg_index <= idx;
        cfg_data <= val[btsp_pkg::PULSE_W-1:0];
        @(posedge clk);
        cfg_write_en <= 0;
        @(posedge clk);
    endtask

    function automatic longint rand_field(input int w);
        longint v;
        v = {$urandom(), $urandom()};
        case ($urandom_range(3))
            0: return v >>> (64 - w);
            1: return (v % 64'sd3600000001) - 64'sd1800000000;
            default: return (v % 64'sd1800000001) - 64'sd900000000;
        endcase
    endfunction

    task automatic random_burst(input int n);
        longint la, lo;
        for (int i = 0; i < n; i++)
        begin
            la = rand_field(btsp_pkg::LAT_W);
            lo = rand_field(btsp_pkg::LON_W);
            if ($urandom_range(9) == 0)
                send_request(la, lo, la, lo);
            else
                send_request(la, lo, rand_field(btsp_pkg::LAT_W),
                             rand_field(btsp_pkg::LON_W));
        end
    endtask

    initial
    begin
        rst_n = 0;
        in_valid = 0; hold_recv = 0;
        origin_latitude = 0; origin_longitude = 0;
        target_latitude = 0; target_longitude = 0;
        cfg_write_en = 0; cfg_index = btsp_pkg::CFG_SERVO_MIN; cfg_data = 0;
        send_idle = 0; recv_idle = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // cardinal directions, coincident, antipodal, beyond-range angles
        send_request(0, 0, 0, 0);
        send_request(0, 0, 100000000, 0);
        send_request(0, 0, -100000000, 0);
        send_request(0, 0, 0, 100000000);
        send_request(0, 0, 0, -100000000);
        send_request(0, 0, 0, 1800000000);
        send_request(0, -1800000000, 0, 1800000000);
        send_request(900000000, 0, -900000000, 0);
        send_request(-900000000, 1800000000, 900000000, -1800000000);
        send_request(1073741823, 64'sd2147483647, -1073741824, -64'sd2147483648);
        send_request(-1073741824, -64'sd2147483648, 1073741823, 64'sd2147483647);
        send_request(450000000, 100000000, 300000000, -1500000000);
        send_request(-450000000, 0, -460000000, 1000);
        send_request(10000000, 0, -10000000, 1000000);
        send_request(0, 0, 0, 64'sd3600000000 - 1);
        drain();

        // inverted and extreme pulse settings
        write_reg(btsp_pkg::CFG_SERVO_MIN, 4095);
        write_reg(btsp_pkg::CFG_SERVO_MAX, 0);
        write_reg(btsp_pkg::CFG_SERVO_CENTER, 0);
        write_reg(btsp_pkg::cfg_idx_t'(3), 77);
        random_burst(40);
        drain();

        write_reg(btsp_pkg::CFG_SERVO_MIN, 0);
        write_reg(btsp_pkg::CFG_SERVO_MAX, 4095);
        write_reg(btsp_pkg::CFG_SERVO_CENTER, 4095);
        send_idle = 7; recv_idle = 87;
        random_burst(350);
        drain();

        write_reg(btsp_pkg::CFG_SERVO_MIN, $urandom_range(4095));
        write_reg(btsp_pkg::CFG_SERVO_MAX, $urandom_range(4095));
        write_reg(btsp_pkg::CFG_SERVO_CENTER, $urandom_range(4095));
        send_idle = 87; recv_idle = 7;
        random_burst(200);
        drain();

        write_reg(btsp_pkg::CFG_SERVO_MIN, 500);
        write_reg(btsp_pkg::CFG_SERVO_MAX, 2500);
        write_reg(btsp_pkg::CFG_SERVO_CENTER, 1500);
        send_idle = 0; recv_idle = 0;
        fork
            begin
                hold_recv = 1;
                repeat (300) @(posedge clk);
                hold_recv = 0;
            end
            random_burst(300);
        join
        drain();
        random_burst(350);
        drain();

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
